>>> rtl/sprite_quad_corner_rotate_unit_defines.svh
// Assertion macros for the sprite quad corner rotate unit.
`ifndef SPRITE_QUAD_CORNER_ROTATE_UNIT_DEFINES_SVH
`define SPRITE_QUAD_CORNER_ROTATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SQCR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqcr assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SQCR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqcr assertion failed");
`else
`define SQCR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SQCR_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sqcr_pkg.sv
package sqcr_pkg;

  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 12;
  localparam int MODE_W    = 2;
  localparam int REG_IDX_W = 2;
  localparam int TURN_W    = 32;

  // CORDIC datapath: 30 fraction bits plus headroom for gain and sign.
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_FRAC  = 30;
  localparam int CW           = 34;
  localparam logic [TURN_W-1:0] CORDIC_INV_GAIN = 32'd652032874;

  // Corner offsets in Q.4 before the anchor is added.
  localparam int OW = 20;

  localparam logic [MODE_W-1:0] PIVOT_CENTER    = 2'd0;
  localparam logic [MODE_W-1:0] PIVOT_TOP_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] PIVOT_TOP_RIGHT = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PIVOT_MODE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd2;

  localparam logic [TURN_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  // Data that rides along the pipeline beside the trig values.
  typedef struct packed {
    logic [1:0]                 quad;
    logic signed [COORD_W-1:0]  anchor_x;
    logic signed [COORD_W-1:0]  anchor_y;
  } side_t;

endpackage

>>> rtl/sprite_quad_corner_rotate_unit.sv
// Sprite quad corner rotate unit. One sprite is taken in every cycle: start is sampled whenever
// busy is low, and busy is high only in the first cycle after reset. The four corners and the
// clip flag sit on the result ports for one cycle, marked by valid_o, and are taken at the
// rising edge at the end of that cycle; the receiver cannot stall the unit.
// The pipeline is the angle split register, the 28-stage CORDIC pipeline that produces sin and
// cos, and seven stages behind it for rounding, quadrant fold, multiply, sum, scaling, offset
// select and saturating add.
// Configuration registers may be written only while no sprite is in flight.
`include "sprite_quad_corner_rotate_unit_defines.svh"

module sprite_quad_corner_rotate_unit #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sqcr_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sqcr_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sqcr_pkg::COORD_W-1:0]  anchor_x_i,
  input  logic signed [sqcr_pkg::COORD_W-1:0]  anchor_y_i,
  input  logic [15:0]                          turn_angle_i,
  output logic                                 valid_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner0_x_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner0_y_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner1_x_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner1_y_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner2_x_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner2_y_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner3_x_o,
  output logic signed [sqcr_pkg::COORD_W-1:0]  corner3_y_o,
  output logic                                 clipped_o
);
  import sqcr_pkg::*;

  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int PW  = TRIG_FRAC_BITS + 16;
  localparam int SH0 = TRIG_FRAC_BITS - 3;
  localparam int SH1 = TRIG_FRAC_BITS - 4;
  localparam int LAT = CORDIC_STEPS + 8;

  localparam logic signed [CW-1:0] TRIG_HALF = CW'(1) << (CORDIC_FRAC - 1 - TRIG_FRAC_BITS);
  localparam logic signed [CW-1:0] TRIG_ONE  = CW'(1) << TRIG_FRAC_BITS;
  localparam logic signed [CW-1:0] TRIG_MONE = -TRIG_ONE;
  localparam logic signed [PW-1:0] HALF0     = PW'(1) << (SH0 - 1);
  localparam logic signed [PW-1:0] HALF1     = PW'(1) << (SH1 - 1);
  localparam logic signed [OW:0]   SAT_MAX   = (OW+1)'(32767);
  localparam logic signed [OW:0]   SAT_MIN   = -(OW+1)'(32768);

  // Configuration registers.
  logic [MODE_W-1:0] cfg_mode_q;
  logic [SIZE_W-1:0] cfg_width_q, cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q   <= PIVOT_CENTER;
      cfg_width_q  <= '0;
      cfg_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PIVOT_MODE:    cfg_mode_q   <= cfg_wdata_i[MODE_W-1:0];
        REG_SPRITE_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        REG_SPRITE_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic busy_q;
  logic in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign in_acc = start && !busy_q;

  // Angle split: nearest quarter turn and a residual in [-1/8, 1/8) turn.
  logic [ANGLE_BITS-1:0] ang;
  logic [TURN_W-1:0]     turn, turn_rnd, resid;
  logic [1:0]            quad;

  always_comb begin
    ang      = ANGLE_BITS'(turn_angle_i);
    turn     = {ang, {(TURN_W-ANGLE_BITS){1'b0}}};
    turn_rnd = turn + 32'h2000_0000;
    quad     = turn_rnd[TURN_W-1:TURN_W-2];
    resid    = turn - {quad, {(TURN_W-2){1'b0}}};
  end

  logic signed [CW-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] cz_q [CORDIC_STEPS+1];
  side_t                side_q [CORDIC_STEPS+1];
  logic                 cv_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    cx_q[0]            <= CW'(CORDIC_INV_GAIN);
    cy_q[0]            <= '0;
    cz_q[0]            <= CW'($signed(resid));
    side_q[0].quad     <= quad;
    side_q[0].anchor_x <= anchor_x_i;
    side_q[0].anchor_y <= anchor_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= in_acc;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] sx, sy, atan_c;

    assign sx     = cy_q[i] >>> i;
    assign sy     = cx_q[i] >>> i;
    assign atan_c = $signed(CW'(CORDIC_ATAN[i]));

    always_ff @(posedge clk_i) begin
      if (!cz_q[i][CW-1]) begin
        cx_q[i+1] <= cx_q[i] - sx;
        cy_q[i+1] <= cy_q[i] + sy;
        cz_q[i+1] <= cz_q[i] - atan_c;
      end else begin
        cx_q[i+1] <= cx_q[i] + sx;
        cy_q[i+1] <= cy_q[i] - sy;
        cz_q[i+1] <= cz_q[i] + atan_c;
      end
      side_q[i+1] <= side_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end
  end

  function automatic logic signed [TW-1:0] trig_round(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + TRIG_HALF) >>> (CORDIC_FRAC - TRIG_FRAC_BITS);
    if (r > TRIG_ONE) begin
      r = TRIG_ONE;
    end
    if (r < TRIG_MONE) begin
      r = TRIG_MONE;
    end
    return TW'(r);
  endfunction

  // Round stage.
  logic signed [TW-1:0] rc_q, rs_q;
  side_t                r1_side_q;
  logic                 r1_v_q;

  always_ff @(posedge clk_i) begin
    rc_q      <= trig_round(cx_q[CORDIC_STEPS]);
    rs_q      <= trig_round(cy_q[CORDIC_STEPS]);
    r1_side_q <= side_q[CORDIC_STEPS];
  end

  // Quadrant fold stage.
  logic signed [TW-1:0] co_d, si_d, co_q, si_q;
  side_t                r2_side_q;
  logic                 r2_v_q;

  always_comb begin
    case (r1_side_q.quad)
      2'd0: begin co_d = rc_q;  si_d = rs_q;  end
      2'd1: begin co_d = -rs_q; si_d = rc_q;  end
      2'd2: begin co_d = -rc_q; si_d = -rs_q; end
      default: begin co_d = rs_q; si_d = -rc_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    co_q      <= co_d;
    si_q      <= si_d;
    r2_side_q <= r1_side_q;
  end

  // Multiply stage: four independent small products.
  logic signed [PW-1:0] w_ext, h_ext, c_ext, s_ext;
  logic signed [PW-1:0] wc_q, ws_q, hc_q, hs_q;
  side_t                m_side_q;
  logic                 m_v_q;

  always_comb begin
    w_ext = PW'($signed({1'b0, cfg_width_q}));
    h_ext = PW'($signed({1'b0, cfg_height_q}));
    c_ext = PW'(co_q);
    s_ext = PW'(si_q);
  end

  always_ff @(posedge clk_i) begin
    wc_q     <= w_ext * c_ext;
    ws_q     <= w_ext * s_ext;
    hc_q     <= h_ext * c_ext;
    hs_q     <= h_ext * s_ext;
    m_side_q <= r2_side_q;
  end

  // Sum stage.
  logic signed [PW-1:0] sp_q, sq_q, sr_q, st_q, swc_q, sws_q, snhs_q, shc_q;
  side_t                a_side_q;
  logic                 a_v_q;

  always_ff @(posedge clk_i) begin
    sp_q     <= wc_q - hs_q;
    sq_q     <= ws_q + hc_q;
    sr_q     <= wc_q + hs_q;
    st_q     <= ws_q - hc_q;
    swc_q    <= wc_q;
    sws_q    <= ws_q;
    snhs_q   <= -hs_q;
    shc_q    <= hc_q;
    a_side_q <= m_side_q;
  end

  // Scale to Q.4 with round half up.
  function automatic logic signed [OW-1:0] rnd_half(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + HALF0) >>> SH0;
    return OW'(r);
  endfunction

  function automatic logic signed [OW-1:0] rnd_full(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + HALF1) >>> SH1;
    return OW'(r);
  endfunction

  logic signed [OW-1:0] sc_d [6];
  logic signed [OW-1:0] sc_q [6];
  side_t                s_side_q;
  logic                 s_v_q;

  always_comb begin
    if (cfg_mode_q == PIVOT_CENTER) begin
      sc_d[0] = rnd_half(sp_q);
      sc_d[1] = rnd_half(sq_q);
      sc_d[2] = rnd_half(sr_q);
      sc_d[3] = rnd_half(st_q);
    end else begin
      sc_d[0] = rnd_full(swc_q);
      sc_d[1] = rnd_full(sws_q);
      sc_d[2] = rnd_full(snhs_q);
      sc_d[3] = rnd_full(shc_q);
    end
    sc_d[4] = rnd_full(sp_q);
    sc_d[5] = rnd_full(sq_q);
  end

  always_ff @(posedge clk_i) begin
    sc_q     <= sc_d;
    s_side_q <= a_side_q;
  end

  // Offset select per pivot mode.
  logic signed [OW-1:0] w16, h16;
  logic signed [OW-1:0] dx_d [4];
  logic signed [OW-1:0] dy_d [4];
  logic signed [OW-1:0] dx_q [4];
  logic signed [OW-1:0] dy_q [4];
  side_t                o_side_q;
  logic                 o_v_q;

  always_comb begin
    w16 = $signed(OW'({cfg_width_q, 4'b0}));
    h16 = $signed(OW'({cfg_height_q, 4'b0}));
    for (int k = 0; k < 4; k++) begin
      dx_d[k] = '0;
      dy_d[k] = '0;
    end
    case (cfg_mode_q)
      PIVOT_CENTER: begin
        dx_d[0] = -sc_q[0]; dy_d[0] = -sc_q[1];
        dx_d[1] = sc_q[2];  dy_d[1] = sc_q[3];
        dx_d[2] = -sc_q[2]; dy_d[2] = -sc_q[3];
        dx_d[3] = sc_q[0];  dy_d[3] = sc_q[1];
      end
      PIVOT_TOP_LEFT: begin
        dx_d[1] = sc_q[0]; dy_d[1] = sc_q[1];
        dx_d[2] = sc_q[2]; dy_d[2] = sc_q[3];
        dx_d[3] = sc_q[4]; dy_d[3] = sc_q[5];
      end
      PIVOT_TOP_RIGHT: begin
        dx_d[0] = -w16;
        dx_d[2] = -w16; dy_d[2] = h16;
        dy_d[3] = h16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    o_side_q <= s_side_q;
  end

  // Anchor add and saturation into the result registers.
  logic signed [OW:0]         sum_x [4];
  logic signed [OW:0]         sum_y [4];
  logic signed [COORD_W-1:0]  cx_d [4];
  logic signed [COORD_W-1:0]  cy_d [4];
  logic signed [COORD_W-1:0]  corner_x_q [4];
  logic signed [COORD_W-1:0]  corner_y_q [4];
  logic                       clip_d, clip_q, valid_q;

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [OW:0] v);
    logic signed [OW:0] r;
    r = v;
    if (v > SAT_MAX) begin
      r = SAT_MAX;
    end else if (v < SAT_MIN) begin
      r = SAT_MIN;
    end
    return COORD_W'(r);
  endfunction

  always_comb begin
    clip_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sum_x[k] = (OW+1)'(o_side_q.anchor_x) + (OW+1)'(dx_q[k]);
      sum_y[k] = (OW+1)'(o_side_q.anchor_y) + (OW+1)'(dy_q[k]);
      cx_d[k]  = sat16(sum_x[k]);
      cy_d[k]  = sat16(sum_y[k]);
      if (sum_x[k] > SAT_MAX || sum_x[k] < SAT_MIN || sum_y[k] > SAT_MAX ||
          sum_y[k] < SAT_MIN) begin
        clip_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    corner_x_q <= cx_d;
    corner_y_q <= cy_d;
    clip_q     <= clip_d;
  end

  // Valid bits of the back end of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q  <= 1'b0;
      r2_v_q  <= 1'b0;
      m_v_q   <= 1'b0;
      a_v_q   <= 1'b0;
      s_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      r1_v_q  <= cv_q[CORDIC_STEPS];
      r2_v_q  <= r1_v_q;
      m_v_q   <= r2_v_q;
      a_v_q   <= m_v_q;
      s_v_q   <= a_v_q;
      o_v_q   <= s_v_q;
      valid_q <= o_v_q;
    end
  end

  assign valid_o     = valid_q;
  assign clipped_o   = clip_q;
  assign corner0_x_o = corner_x_q[0];
  assign corner0_y_o = corner_y_q[0];
  assign corner1_x_o = corner_x_q[1];
  assign corner1_y_o = corner_y_q[1];
  assign corner2_x_o = corner_x_q[2];
  assign corner2_y_o = corner_y_q[2];
  assign corner3_x_o = corner_x_q[3];
  assign corner3_y_o = corner_y_q[3];

  // Every transfer yields exactly one result a fixed number of cycles later.
  `SQCR_ASSERT_IMP(a_fixed_latency, clk_i, rst_ni, 1'b1, valid_o == $past(in_acc, LAT))
  // A clipped result has at least one coordinate pinned at a rail.
  `SQCR_ASSERT_IMP(a_clip_at_rail, clk_i, rst_ni, valid_o && clipped_o,
    (corner0_x_o == 16'sh7FFF || corner0_x_o == -16'sh8000 ||
     corner0_y_o == 16'sh7FFF || corner0_y_o == -16'sh8000 ||
     corner1_x_o == 16'sh7FFF || corner1_x_o == -16'sh8000 ||
     corner1_y_o == 16'sh7FFF || corner1_y_o == -16'sh8000 ||
     corner2_x_o == 16'sh7FFF || corner2_x_o == -16'sh8000 ||
     corner2_y_o == 16'sh7FFF || corner2_y_o == -16'sh8000 ||
     corner3_x_o == 16'sh7FFF || corner3_x_o == -16'sh8000 ||
     corner3_y_o == 16'sh7FFF || corner3_y_o == -16'sh8000))
  // Busy is released in the cycle after reset ends and never rises again.
  `SQCR_ASSERT_NXT(a_busy_low, clk_i, rst_ni, rst_ni, !busy)

endmodule

>>> tb/sprite_quad_corner_rotate_unit_test.sv
`timescale 1ns / 1ps

module sprite_quad_corner_rotate_unit_test;
  import sqcr_pkg::*;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int RANDOM_ITEMS   = 650;
  localparam int MAX_GAP        = 18;
  localparam int DRAIN_CYCLES   = 48;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 200;

  localparam logic [MODE_W-1:0]    PIVOT_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [3:0][COORD_W-1:0] cx;
    logic [3:0][COORD_W-1:0] cy;
    logic                    clipped;
  } quad_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic [15:0]               ang;
    logic                      typed;
    quad_t                     want;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [SIZE_W-1:0]         cfg_wdata_i = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] anchor_x_i = '0;
  logic signed [COORD_W-1:0] anchor_y_i = '0;
  logic [15:0]               turn_angle_i = '0;
  logic                      valid_o;
  logic signed [COORD_W-1:0] corner0_x_o, corner0_y_o, corner1_x_o, corner1_y_o;
  logic signed [COORD_W-1:0] corner2_x_o, corner2_y_o, corner3_x_o, corner3_y_o;
  logic                      clipped_o;

  // Shadow of the configuration registers as the block should hold them.
  logic [MODE_W-1:0] cur_mode = PIVOT_CENTER;
  logic [SIZE_W-1:0] cur_w = '0;
  logic [SIZE_W-1:0] cur_h = '0;

  quad_t     pending_corners [$];
  stim_row_t dir_rows [$];
  int        fail_count = 0;
  int        cycle_count = 0;

  // Arctangent of 2^-i as a fraction of a full turn, 32 fraction bits.
  logic [31:0] atan_turn [0:27] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  sprite_quad_corner_rotate_unit #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .anchor_x_i  (anchor_x_i),
    .anchor_y_i  (anchor_y_i),
    .turn_angle_i(turn_angle_i),
    .valid_o     (valid_o),
    .corner0_x_o (corner0_x_o),
    .corner0_y_o (corner0_y_o),
    .corner1_x_o (corner1_x_o),
    .corner1_y_o (corner1_y_o),
    .corner2_x_o (corner2_x_o),
    .corner2_y_o (corner2_y_o),
    .corner3_x_o (corner3_x_o),
    .corner3_y_o (corner3_y_o),
    .clipped_o   (clipped_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sprite_quad_corner_rotate_unit: mismatch");
      $finish;
    end
  end

  function automatic longint trig_round(input longint v);
    longint lim;
    longint r;
    lim = longint'(1) << TRIG_FRAC_BITS;
    r = (v + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // The angle is folded to the nearest quarter turn, the residual goes through
  // the CORDIC, and the rounded pair is rotated back by the quadrant.
  function automatic void turn_to_trig(input logic [15:0] ang, output longint co,
                                       output longint si);
    logic [31:0] t;
    logic [31:0] ru;
    logic [31:0] qsum;
    logic [1:0]  q;
    longint      x, y, z, dx, dy, c, s;
    t = 32'((64'(ang) & ((64'd1 << ANGLE_BITS) - 64'd1)) << (32 - ANGLE_BITS));
    qsum = t + 32'h2000_0000;
    q = qsum[31:30];
    ru = t - {q, 30'd0};
    z = longint'($signed(ru));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_turn[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_turn[i]);
      end
    end
    c = trig_round(x);
    s = trig_round(y);
    case (q)
      2'd0: begin
        co = c;
        si = s;
      end
      2'd1: begin
        co = -s;
        si = c;
      end
      2'd2: begin
        co = -c;
        si = -s;
      end
      default: begin
        co = s;
        si = -c;
      end
    endcase
  endfunction

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v, inout logic clip);
    if (v > 32767) begin
      clip = 1'b1;
      return 16'h7FFF;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic quad_t corners_for_sprite(input logic signed [COORD_W-1:0] ax,
                                               input logic signed [COORD_W-1:0] ay,
                                               input logic [15:0] ang);
    quad_t  res;
    longint w, h, c, s, px, py;
    longint ox, oy, bx, by;
    longint dx [4];
    longint dy [4];
    logic   clip;
    w = longint'(cur_w);
    h = longint'(cur_h);
    px = longint'(ax);
    py = longint'(ay);
    clip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      dx[k] = 0;
      dy[k] = 0;
    end
    turn_to_trig(ang, c, s);
    case (cur_mode)
      PIVOT_CENTER: begin
        // Half extents land in Q.4 with one shift more than full extents.
        ox = round_half_up(w * c - h * s, TRIG_FRAC_BITS - 3);
        oy = round_half_up(w * s + h * c, TRIG_FRAC_BITS - 3);
        bx = round_half_up(w * c + h * s, TRIG_FRAC_BITS - 3);
        by = round_half_up(w * s - h * c, TRIG_FRAC_BITS - 3);
        dx[0] = -ox;
        dy[0] = -oy;
        dx[1] = bx;
        dy[1] = by;
        dx[2] = -bx;
        dy[2] = -by;
        dx[3] = ox;
        dy[3] = oy;
      end
      PIVOT_TOP_LEFT: begin
        dx[1] = round_half_up(w * c, TRIG_FRAC_BITS - 4);
        dy[1] = round_half_up(w * s, TRIG_FRAC_BITS - 4);
        dx[2] = round_half_up(-h * s, TRIG_FRAC_BITS - 4);
        dy[2] = round_half_up(h * c, TRIG_FRAC_BITS - 4);
        dx[3] = round_half_up(w * c - h * s, TRIG_FRAC_BITS - 4);
        dy[3] = round_half_up(w * s + h * c, TRIG_FRAC_BITS - 4);
      end
      PIVOT_TOP_RIGHT: begin
        dx[0] = -w * 16;
        dx[2] = -w * 16;
        dy[2] = h * 16;
        dy[3] = h * 16;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      res.cx[k] = clamp_coord(px + dx[k], clip);
      res.cy[k] = clamp_coord(py + dy[k], clip);
    end
    res.clipped = clip;
    return res;
  endfunction

  function automatic quad_t quad_of(input int x0, y0, x1, y1, x2, y2, x3, y3,
                                    input logic clip);
    quad_t q;
    q.cx = {16'(x3), 16'(x2), 16'(x1), 16'(x0)};
    q.cy = {16'(y3), 16'(y2), 16'(y1), 16'(y0)};
    q.clipped = clip;
    return q;
  endfunction

  function automatic stim_row_t stim_row(input logic [MODE_W-1:0] mode, input int w, h,
                                         input int ax, ay, ang, input logic typed,
                                         input quad_t want);
    stim_row_t r;
    r.mode = mode;
    r.w = SIZE_W'(w);
    r.h = SIZE_W'(h);
    r.ax = 16'(ax);
    r.ay = 16'(ay);
    r.ang = 16'(ang);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 15))
                                  : 16'h8000 + 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 12'hFFF;
      2, 3: return 12'($urandom);
      default: return 12'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic apply_config(input logic [SIZE_W-1:0] mode_word, input logic [SIZE_W-1:0] w,
                              input logic [SIZE_W-1:0] h, input bit poke_unused);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_PIVOT_MODE;
    cfg_wdata_i <= mode_word;
    @(posedge clk_i);
    cfg_idx_i <= REG_SPRITE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= REG_SPRITE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx_i <= REG_UNUSED;
      cfg_wdata_i <= 12'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_mode = mode_word[MODE_W-1:0];
    cur_w = w;
    cur_h = h;
  endtask

  task automatic wait_for_all_corners();
    start <= 1'b0;
    while (pending_corners.size() != 0) @(posedge clk_i);
  endtask

  // Holds the sprite on the inputs until the block takes it. Busy is looked at
  // on the falling edge, where it is stable for the next rising edge.
  task automatic send_sprite(input logic signed [COORD_W-1:0] ax,
                             input logic signed [COORD_W-1:0] ay,
                             input logic [15:0] ang, input quad_t want, input int gap);
    bit taken;
    start <= 1'b1;
    anchor_x_i <= ax;
    anchor_y_i <= ay;
    turn_angle_i <= ang;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    pending_corners.push_back(want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic note_field(input string label, input logic [COORD_W-1:0] exp_v,
                            input logic [COORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t %s expected %0d actual %0d", $time, label, $signed(exp_v),
                 $signed(act_v));
    end
  endtask

  always @(negedge clk_i) begin : check_corners
    quad_t want;
    quad_t got;
    if (rst_ni && valid_o) begin
      got.cx = {corner3_x_o, corner2_x_o, corner1_x_o, corner0_x_o};
      got.cy = {corner3_y_o, corner2_y_o, corner1_y_o, corner0_y_o};
      got.clipped = clipped_o;
      if (pending_corners.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t unexpected result transfer, expected none, actual corner0 (%0d,%0d)",
                   $time, corner0_x_o, corner0_y_o);
      end else begin
        want = pending_corners.pop_front();
        for (int k = 0; k < 4; k++) begin
          note_field($sformatf("corner%0d_x", k), want.cx[k], got.cx[k]);
          note_field($sformatf("corner%0d_y", k), want.cy[k], got.cy[k]);
        end
        note_field("clipped", {15'd0, want.clipped}, {15'd0, got.clipped});
      end
    end
  end

  initial begin : stimulus
    stim_row_t          r;
    quad_t              want;
    logic [MODE_W-1:0]  mode;
    logic [SIZE_W-1:0]  mode_word;
    logic [15:0]        ang;
    int                 sent;
    int                 burst;
    bit                 no_gaps;

    // Zero size right after reset: every corner sits on the anchor.
    dir_rows.push_back(stim_row(PIVOT_CENTER, 0, 0, 4660, -100, 16'h4000, 1'b1,
                                quad_of(4660, -100, 4660, -100, 4660, -100, 4660, -100, 0)));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 0, 0, 32767, -32768, 16'hFFFF, 1'b1,
                                quad_of(32767, -32768, 32767, -32768, 32767, -32768,
                                        32767, -32768, 0)));
    // Unrotated quad hanging left and down from its top-right corner.
    dir_rows.push_back(stim_row(PIVOT_TOP_RIGHT, 10, 5, 0, 0, 16'h1234, 1'b1,
                                quad_of(-160, 0, 0, 0, -160, 80, 0, 80, 0)));
    dir_rows.push_back(stim_row(PIVOT_TOP_RIGHT, 4095, 4095, -32768, 32767, 16'h8000, 1'b1,
                                quad_of(-32768, 32767, -32768, 32767, -32768, 32767,
                                        -32768, 32767, 1)));
    dir_rows.push_back(stim_row(PIVOT_TOP_RIGHT, 4095, 4095, 32767, -32768, 16'h0000, 1'b1,
                                quad_of(-32753, -32768, 32767, -32768, -32753, 32752,
                                        32767, 32752, 0)));
    // The unused pivot mode collapses the quad onto the anchor.
    dir_rows.push_back(stim_row(PIVOT_UNUSED, 100, 200, -5, 7, 16'h2000, 1'b1,
                                quad_of(-5, 7, -5, 7, -5, 7, -5, 7, 0)));
    dir_rows.push_back(stim_row(PIVOT_UNUSED, 100, 200, -32768, 32767, 16'hFFFF, 1'b1,
                                quad_of(-32768, 32767, -32768, 32767, -32768, 32767,
                                        -32768, 32767, 0)));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'h0000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'h2000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'h4000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'h8000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'hC000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'hFFFF, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 0, 0, 16'h1FFF, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 4095, 4095, 32767, -32768, 16'h6000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 64, 32, 100, -100, 16'h0001, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 64, 32, 100, -100, 16'h5FFF, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_CENTER, 64, 32, 100, -100, 16'hA000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_TOP_LEFT, 4095, 1, -32768, 32767, 16'h0000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_TOP_LEFT, 4095, 1, -32768, 32767, 16'h4000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_TOP_LEFT, 4095, 1, -32768, 32767, 16'hE000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_TOP_LEFT, 1, 4095, 16, 16, 16'h2000, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_TOP_LEFT, 1, 4095, 16, 16, 16'h9FFF, 1'b0, '0));
    dir_rows.push_back(stim_row(PIVOT_TOP_LEFT, 1, 4095, 16, 16, 16'h7FFF, 1'b0, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.mode != cur_mode || r.w != cur_w || r.h != cur_h) begin
        wait_for_all_corners();
        apply_config({10'd0, r.mode}, r.w, r.h, 1'b0);
      end
      want = r.typed ? r.want : corners_for_sprite(r.ax, r.ay, r.ang);
      send_sprite(r.ax, r.ay, r.ang, want, $urandom_range(0, MAX_GAP));
    end

    // Random bursts, each under a fresh configuration written while idle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_for_all_corners();
      case ($urandom_range(0, 9))
        0, 1, 2: mode = PIVOT_CENTER;
        3, 4, 5: mode = PIVOT_TOP_LEFT;
        6, 7, 8: mode = PIVOT_TOP_RIGHT;
        default: mode = PIVOT_UNUSED;
      endcase
      // Bits above the mode field are don't-care for the block.
      mode_word = $urandom_range(0, 1) ? {10'($urandom), mode} : {10'd0, mode};
      apply_config(mode_word, rand_size(), rand_size(), $urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 70);
      no_gaps = $urandom_range(0, 3) == 0;
      repeat (burst) begin
        if ($urandom_range(0, 3) == 0)
          ang = 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 8) - 4);
        else
          ang = 16'($urandom);
        r.ax = rand_coord();
        r.ay = rand_coord();
        send_sprite(r.ax, r.ay, ang, corners_for_sprite(r.ax, r.ay, ang),
                    no_gaps ? 0 : $urandom_range(0, MAX_GAP));
        sent++;
      end
    end

    wait_for_all_corners();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("sprite_quad_corner_rotate_unit: match");
    else
      $display("sprite_quad_corner_rotate_unit: mismatch");
    $finish;
  end

endmodule

>>> sprite_quad_corner_rotate_unit.f
+incdir+rtl
rtl/sqcr_pkg.sv
rtl/sprite_quad_corner_rotate_unit.sv
tb/sprite_quad_corner_rotate_unit_test.sv
